### src/wof_pkg.sv
// Shared constants, types and character helpers for the word occurrence finder.
package wof_pkg;

    localparam int CHAR_W   = 8;
    localparam int MAX_WORD = 16;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int POS_W    = $clog2(MAX_WORD);
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LOW  = 2'd0,
        CFG_TARGET_HIGH = 2'd1,
        CFG_TARGET_LEN  = 2'd2
    } cfg_idx_t;

    // Target word as the matcher sees it: characters already lower-cased.
    typedef struct packed {
        logic [MAX_WORD-1:0][CHAR_W-1:0] chars;
        logic [LEN_W-1:0]                len;
    } target_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        l = fold(c);
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

### src/wof_cfg.sv
// Configuration registers holding the lower-cased target word and its length.
module wof_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [wof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wof_pkg::CFG_W-1:0]        cfg_wdata,
    output wof_pkg::target_t                 target
);

    localparam int HALF = wof_pkg::MAX_WORD / 2;

    logic [HALF-1:0][wof_pkg::CHAR_W-1:0] low_reg;
    logic [HALF-1:0][wof_pkg::CHAR_W-1:0] high_reg;
    logic [wof_pkg::LEN_W-1:0]            len_reg;
    logic [HALF-1:0][wof_pkg::CHAR_W-1:0] folded;

    // Fold on the way in so the per-byte compare needs no case logic on the target side.
    always_comb begin
        for (int i = 0; i < HALF; i++) begin
            folded[i] = wof_pkg::fold(cfg_wdata[i*wof_pkg::CHAR_W +: wof_pkg::CHAR_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= wof_pkg::LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                wof_pkg::CFG_TARGET_LOW:  low_reg  <= folded;
                wof_pkg::CFG_TARGET_HIGH: high_reg <= folded;
                wof_pkg::CFG_TARGET_LEN:  len_reg  <= cfg_wdata[wof_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign target.chars = {high_reg, low_reg};
    assign target.len   = len_reg;

endmodule

### src/wof_matcher.sv
// Token state, line and match counters, and the per-byte match decision.
module wof_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [wof_pkg::CHAR_W-1:0]     text_byte,
    input  logic                           end_of_text,
    input  wof_pkg::target_t               target,
    output logic                           hit,
    output logic [wof_pkg::CNT_W-1:0]      hit_line,
    output logic [wof_pkg::CNT_W-1:0]      hit_count,
    output logic                           hit_first
);

    logic                          inside_reg, inside_next;
    logic                          mismatch_reg, mismatch_next;
    logic [wof_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [wof_pkg::CNT_W-1:0]     line_reg, line_next;
    logic [wof_pkg::CNT_W-1:0]     total_reg, total_next;
    logic                          line_hit_reg, line_hit_next;

    logic                          sep;
    logic                          lf;
    logic                          len_full;
    logic [wof_pkg::CHAR_W-1:0]    tgt_char;
    logic                          mis_add;
    logic [wof_pkg::LEN_W-1:0]     len_add;
    logic                          len_ok;
    logic                          hit_sep;
    logic                          hit_add;
    logic [wof_pkg::CNT_W-1:0]     total_inc;
    logic [wof_pkg::CNT_W-1:0]     line_inc;

    assign sep      = wof_pkg::is_sep(text_byte);
    assign lf       = (text_byte == wof_pkg::CH_LF);
    assign len_full = (len_reg >= wof_pkg::LEN_W'(wof_pkg::MAX_WORD));
    assign tgt_char = target.chars[len_reg[wof_pkg::POS_W-1:0]];
    assign len_ok   = (target.len != '0) &&
                      (target.len <= wof_pkg::LEN_W'(wof_pkg::MAX_WORD));

    // State after taking the byte as a token character.
    always_comb begin
        mis_add = mismatch_reg;
        len_add = len_reg;
        if (!inside_reg && !wof_pkg::is_letter(text_byte)) begin
            // non-letter opening character is dropped
        end else if (len_full) begin
            mis_add = 1'b1;
        end else begin
            mis_add = mismatch_reg | (wof_pkg::fold(text_byte) != tgt_char);
            len_add = len_reg + wof_pkg::LEN_W'(1);
        end
    end

    assign hit_sep   = inside_reg && !mismatch_reg && len_ok && (len_reg == target.len);
    assign hit_add   = !mis_add && len_ok && (len_add == target.len);
    assign hit       = sep ? hit_sep : (end_of_text && hit_add);
    assign total_inc = (total_reg == wof_pkg::CNT_MAX) ? total_reg
                                                       : total_reg + wof_pkg::CNT_W'(1);
    assign line_inc  = (line_reg == wof_pkg::CNT_MAX) ? line_reg
                                                      : line_reg + wof_pkg::CNT_W'(1);

    assign hit_line  = line_reg;
    assign hit_count = total_inc;
    assign hit_first = !line_hit_reg;

    always_comb begin
        inside_next   = inside_reg;
        mismatch_next = mismatch_reg;
        len_next      = len_reg;
        line_next     = line_reg;
        total_next    = total_reg;
        line_hit_next = line_hit_reg;
        if (step) begin
            if (end_of_text) begin
                inside_next   = 1'b0;
                mismatch_next = 1'b0;
                len_next      = '0;
                line_next     = wof_pkg::CNT_W'(1);
                total_next    = '0;
                line_hit_next = 1'b0;
            end else if (sep) begin
                inside_next   = 1'b0;
                mismatch_next = 1'b0;
                len_next      = '0;
                if (hit) begin
                    total_next    = total_inc;
                    line_hit_next = 1'b1;
                end
                if (lf) begin
                    line_next     = line_inc;
                    line_hit_next = 1'b0;
                end
            end else begin
                inside_next   = 1'b1;
                mismatch_next = mis_add;
                len_next      = len_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg   <= 1'b0;
            mismatch_reg <= 1'b0;
            len_reg      <= '0;
            line_reg     <= wof_pkg::CNT_W'(1);
            total_reg    <= '0;
            line_hit_reg <= 1'b0;
        end else begin
            inside_reg   <= inside_next;
            mismatch_reg <= mismatch_next;
            len_reg      <= len_next;
            line_reg     <= line_next;
            total_reg    <= total_next;
            line_hit_reg <= line_hit_next;
        end
    end

endmodule

### src/word_occurrence_finder.sv
// Top level: input register, matcher, result register and configuration port.
//
// Case-insensitive whole-word finder over a byte stream.
// Input channel (s_*): one text byte per beat plus an end-of-text flag.
// Result channel (m_*): one beat per match with the line number, the
// running occurrence count and a first-hit-on-this-line flag.
// Configuration (cfg_*): write-only registers for the target word and its
// length; write them only while no beats are in flight.
// A byte accepted into the input register is compared by the matcher there, and
// its result (if any) is loaded into the result register when the byte advances.
// Throughput: one byte per cycle while a stalled m_ready does not hold the bytes;
// the character compare is combinational and the token state updates as each byte advances.
// A stalled m_ready holds the result register; the input register keeps one
// byte waiting behind it, and s_ready drops only when both are occupied.
// Reset (synchronous, aresetn low) empties both registers, sets the line to 1,
// clears the count and token state, and restores the target registers.
// End of text closes the last token and returns all counters to reset values.
module word_occurrence_finder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_text_byte,
    input  logic                             s_end_of_text,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_line_number,
    output logic [31:0]                      m_occurrence_count,
    output logic                             m_first_hit_on_line,
    input  logic                             cfg_we,
    input  logic [wof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wof_pkg::CFG_W-1:0]        cfg_wdata
);

    wof_pkg::target_t               target;

    logic                           in_valid_reg;
    logic [wof_pkg::CHAR_W-1:0]     in_byte_reg;
    logic                           in_eot_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [wof_pkg::CNT_W-1:0]      out_line_reg;
    logic [wof_pkg::CNT_W-1:0]      out_count_reg;
    logic                           out_first_reg;

    logic                           advance;
    logic                           hit;
    logic [wof_pkg::CNT_W-1:0]      hit_line;
    logic [wof_pkg::CNT_W-1:0]      hit_count;
    logic                           hit_first;

    wof_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .target    (target)
    );

    // Byte in the input register moves on when the result slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    wof_matcher u_matcher (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .target      (target),
        .hit         (hit),
        .hit_line    (hit_line),
        .hit_count   (hit_count),
        .hit_first   (hit_first)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = hit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hit) begin
            out_line_reg  <= hit_line;
            out_count_reg <= hit_count;
            out_first_reg <= hit_first;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_line_number       = out_line_reg;
    assign m_occurrence_count  = out_count_reg;
    assign m_first_hit_on_line = out_first_reg;

endmodule
